@@ sv/rts_pkg.sv @@
`timescale 1ns / 1ps

package rts_pkg;

   localparam int CODE_W   = 16;
   localparam int ADDR_W   = 24;
   localparam int TICK_W   = 18;
   localparam int FRAME_W  = 56;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 24;

   // command codes
   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_SEND = 2'd1;
   localparam logic [1:0] CMD_LOAD = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOL_TICKS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REMOTE_ID_BASE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REMOTE_COUNT   = 2'd2;

   // fixed waveform durations in ticks
   localparam logic [TICK_W-1:0] WAKE_HI_TICKS = 18'd9415;
   localparam logic [TICK_W-1:0] WAKE_LO_TICKS = 18'd89565;
   localparam logic [TICK_W-1:0] SS_HI_TICKS   = 18'd4550;
   localparam logic [TICK_W-1:0] GAP_TICKS     = 18'd30415;

   localparam logic [7:0] FRAME_KEY     = 8'hA7;
   localparam logic [6:0] HALF_BITS     = 7'd112;
   localparam logic [1:0] FRAME_REPEATS = 2'd3;
   localparam logic [2:0] FIRST_SYNC    = 3'd2;
   localparam logic [2:0] REPEAT_SYNC   = 3'd7;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_WAKE_HI = 4'd1,
      PH_WAKE_LO = 4'd2,
      PH_HS_HI   = 4'd3,
      PH_HS_LO   = 4'd4,
      PH_SS_HI   = 4'd5,
      PH_SS_LO   = 4'd6,
      PH_DATA    = 4'd7,
      PH_GAP     = 4'd8
   } phase_type;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [3:0]        remote_index;
      logic [3:0]        button;
      logic [CODE_W-1:0] code_value;
   } req_type;

   typedef struct packed {
      logic              pin_level;
      logic              busy_res;
      logic              accepted;
      logic [CODE_W-1:0] code_used;
   } rsp_type;

endpackage

@@ sv/rts_code_ram.sv @@
`timescale 1ns / 1ps

module rts_code_ram #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [rts_pkg::CODE_W-1:0] rd_data,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [rts_pkg::CODE_W-1:0] wr_data
);
   import rts_pkg::*;

   logic [CODE_W-1:0] mem [DEPTH];
   logic [CODE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read returns the old word on a same-edge write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/rts_rolling_code_transmitter_unit.sv @@
// a transaction is accepted into s1 while its code word is read from the code memory, and
//   its response is registered when s1 advances, which a stalled waiting response holds off
// throughput: one transaction per cycle while the response side does not stall, set by the
//   read-modify-write of the code memory with write forwarding; req_stall rises only while a response waits
// reset: synchronous active-high; clears sequencer, code valid bits and pipeline valids, sets config defaults
`timescale 1ns / 1ps

module rts_rolling_code_transmitter_unit #(
   parameter int NUM_REMOTES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  rts_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output rts_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [rts_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rts_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import rts_pkg::*;

   localparam int AW = (NUM_REMOTES > 1) ? $clog2(NUM_REMOTES) : 1;

   // configuration registers
   logic [15:0]       sym_cfg_ff;
   logic [ADDR_W-1:0] base_cfg_ff;
   logic [4:0]        count_cfg_ff;

   // sequencer state
   phase_type          phase_ff, phase_in;
   logic               level_ff, level_in;
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [1:0]         rep_ff, rep_in;
   logic [2:0]         sync_ff, sync_in;
   logic [6:0]         hbi_ff, hbi_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;

   // pipeline: s1 holds the transaction whose code word is being read
   logic    s1_valid_ff;
   req_type s1_req_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_in;

   // code memory, valid bits and write forwarding
   logic [NUM_REMOTES-1:0] rc_valid_ff;
   logic                   fwd_valid_ff;
   logic [AW-1:0]          fwd_addr_ff;
   logic [CODE_W-1:0]      fwd_data_ff;
   logic [CODE_W-1:0]      rd_data;
   logic                   wr_en;
   logic [CODE_W-1:0]      wr_data;
   logic [AW-1:0]          s1_addr;
   logic [CODE_W-1:0]      code_now;

   logic req_fire;
   logic s1_go;

   // combinational helpers
   logic               busy;
   logic               ok;
   logic [15:0]        sym;
   logic [TICK_W-1:0]  sym4;
   logic [TICK_W-1:0]  tick_dec;
   logic               enter_en;
   phase_type          enter_ph;
   logic [5:0]         bitpos;
   logic               dbit;
   logic [FRAME_W-1:0] new_frame;

   assign s1_go     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_go;
   assign req_fire  = req_valid && !req_stall;

   assign s1_addr = AW'(s1_req_ff.remote_index);

   rts_code_ram #(
      .DEPTH  (NUM_REMOTES),
      .ADDR_W (AW)
   ) u_code_ram (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (AW'(req_data.remote_index)),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (s1_addr),
      .wr_data (wr_data)
   );

   // newest value of the addressed code: the write from the last processed
   // transaction wins over the registered read, an unwritten entry reads zero
   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == s1_addr)) begin
         code_now = fwd_data_ff;
      end else if (rc_valid_ff[s1_addr]) begin
         code_now = rd_data;
      end else begin
         code_now = '0;
      end
   end

   // frame: key, button and checksum, code big-endian, address, then byte chaining
   function automatic logic [FRAME_W-1:0] build_frame(input logic [ADDR_W-1:0] base,
                                                      input logic [3:0] idx,
                                                      input logic [3:0] btn,
                                                      input logic [CODE_W-1:0] code);
      logic [ADDR_W-1:0] addr;
      logic [7:0]        f [7];
      logic [3:0]        cs;
      logic [FRAME_W-1:0] bits;
      addr = base + ADDR_W'(idx);
      f[0] = FRAME_KEY;
      f[1] = {btn, 4'b0000};
      f[2] = code[15:8];
      f[3] = code[7:0];
      f[4] = addr[23:16];
      f[5] = addr[15:8];
      f[6] = addr[7:0];
      cs = '0;
      for (int i = 0; i < 7; i++) begin
         cs = cs ^ f[i][7:4] ^ f[i][3:0];
      end
      f[1] = f[1] | {4'b0000, cs};
      for (int i = 1; i < 7; i++) begin
         f[i] = f[i] ^ f[i-1];
      end
      bits = {f[0], f[1], f[2], f[3], f[4], f[5], f[6]};
      return bits;
   endfunction

   assign sym  = (sym_cfg_ff == 16'd0) ? 16'd1 : sym_cfg_ff;
   assign sym4 = {sym, 2'b00};
   assign busy = (phase_ff != PH_IDLE);
   assign ok   = !busy && ({1'b0, s1_req_ff.remote_index} < count_cfg_ff) &&
                 (int'(s1_req_ff.remote_index) < NUM_REMOTES);
   assign tick_dec  = tick_ff - TICK_W'(1);
   assign new_frame = build_frame(base_cfg_ff, s1_req_ff.remote_index,
                                  s1_req_ff.button, code_now);

   always_comb begin
      phase_in = phase_ff;
      level_in = level_ff;
      tick_in  = tick_ff;
      rep_in   = rep_ff;
      sync_in  = sync_ff;
      hbi_in   = hbi_ff;
      frame_in = frame_ff;
      wr_en    = 1'b0;
      wr_data  = s1_req_ff.code_value;
      enter_en = 1'b0;
      enter_ph = PH_IDLE;
      bitpos   = '0;
      dbit     = 1'b0;
      rsp_in   = '0;

      if (s1_go) begin
         unique case (s1_req_ff.cmd)
            CMD_TICK: begin
               if (busy) begin
                  tick_in = tick_dec;
                  if (tick_dec == '0) begin
                     enter_en = 1'b1;
                     unique case (phase_ff)
                        PH_WAKE_HI: enter_ph = PH_WAKE_LO;
                        PH_WAKE_LO: enter_ph = PH_HS_HI;
                        PH_HS_HI:   enter_ph = PH_HS_LO;
                        PH_HS_LO: begin
                           sync_in  = sync_ff - 3'd1;
                           enter_ph = (sync_in != 3'd0) ? PH_HS_HI : PH_SS_HI;
                        end
                        PH_SS_HI:   enter_ph = PH_SS_LO;
                        PH_SS_LO: begin
                           hbi_in   = '0;
                           enter_ph = PH_DATA;
                        end
                        PH_DATA: begin
                           hbi_in   = hbi_ff + 7'd1;
                           enter_ph = (hbi_in < HALF_BITS) ? PH_DATA : PH_GAP;
                        end
                        PH_GAP: begin
                           rep_in = rep_ff + 2'd1;
                           if (rep_in < FRAME_REPEATS) begin
                              sync_in  = REPEAT_SYNC;
                              enter_ph = PH_HS_HI;
                           end else begin
                              rep_in   = '0;
                              enter_ph = PH_IDLE;
                           end
                        end
                        default: enter_ph = PH_IDLE;
                     endcase
                  end
               end
            end
            CMD_SEND: begin
               if (ok) begin
                  frame_in = new_frame;
                  wr_en    = 1'b1;
                  wr_data  = code_now + CODE_W'(1);
                  rep_in   = '0;
                  sync_in  = FIRST_SYNC;
                  hbi_in   = '0;
                  enter_en = 1'b1;
                  enter_ph = PH_WAKE_HI;
                  rsp_in.accepted  = 1'b1;
                  rsp_in.code_used = code_now;
               end
            end
            CMD_LOAD: begin
               if (ok) begin
                  wr_en   = 1'b1;
                  wr_data = s1_req_ff.code_value;
                  rsp_in.accepted = 1'b1;
               end
            end
            default: ;
         endcase
      end

      // entering a phase sets the pin level and the duration
      if (enter_en) begin
         phase_in = enter_ph;
         unique case (enter_ph)
            PH_WAKE_HI: begin level_in = 1'b1; tick_in = WAKE_HI_TICKS; end
            PH_WAKE_LO: begin level_in = 1'b0; tick_in = WAKE_LO_TICKS; end
            PH_HS_HI:   begin level_in = 1'b1; tick_in = sym4; end
            PH_HS_LO:   begin level_in = 1'b0; tick_in = sym4; end
            PH_SS_HI:   begin level_in = 1'b1; tick_in = SS_HI_TICKS; end
            PH_SS_LO:   begin level_in = 1'b0; tick_in = TICK_W'(sym); end
            PH_DATA: begin
               // manchester: a one is low then high, msb first
               bitpos   = 6'(6'd55 - hbi_in[6:1]);
               dbit     = frame_in[bitpos];
               level_in = hbi_in[0] ? dbit : ~dbit;
               tick_in  = TICK_W'(sym);
            end
            PH_GAP:     begin level_in = 1'b0; tick_in = GAP_TICKS; end
            default: begin
               phase_in = PH_IDLE;
               level_in = 1'b0;
               tick_in  = '0;
            end
         endcase
      end

      // a tick reports the level during it, anything else the level now driven
      if (s1_req_ff.cmd == CMD_TICK) begin
         rsp_in.pin_level = busy ? level_ff : 1'b0;
      end else begin
         rsp_in.pin_level = level_in;
      end
      rsp_in.busy_res = (phase_in != PH_IDLE);
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         sym_cfg_ff   <= 16'd640;
         base_cfg_ff  <= '0;
         count_cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SYMBOL_TICKS:   sym_cfg_ff   <= csr_wdata[15:0];
            CSR_REMOTE_ID_BASE: base_cfg_ff  <= csr_wdata[ADDR_W-1:0];
            CSR_REMOTE_COUNT:   count_cfg_ff <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         level_ff <= 1'b0;
         tick_ff  <= '0;
         rep_ff   <= '0;
         sync_ff  <= '0;
         hbi_ff   <= '0;
         frame_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         level_ff <= level_in;
         tick_ff  <= tick_in;
         rep_ff   <= rep_in;
         sync_ff  <= sync_in;
         hbi_ff   <= hbi_in;
         frame_ff <= frame_in;
      end
   end

   // code valid bits and forwarding of the last write
   always_ff @(posedge clock) begin
      if (reset) begin
         rc_valid_ff  <= '0;
         fwd_valid_ff <= 1'b0;
      end else if (s1_go) begin
         fwd_valid_ff <= wr_en;
         if (wr_en) begin
            rc_valid_ff[s1_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         fwd_addr_ff <= s1_addr;
         fwd_data_ff <= wr_data;
      end
   end

   // transaction pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff <= req_data;
      end
      if (s1_go) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ tb/sv/rts_rolling_code_transmitter_unit_checker.sv @@
`timescale 1ns / 1ps

module rts_rolling_code_transmitter_unit_checker #(
   parameter int NUM_REMOTES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  rts_pkg::req_type              req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  rts_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [rts_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rts_pkg::CSR_DAT_W-1:0] csr_wdata,
   output int                            fail_count,
   output int                            pending_results
);

   import rts_pkg::*;

   // register copies
   logic [15:0]        symbol_len;
   logic [ADDR_W-1:0]  id_base;
   logic [4:0]         remotes_used;

   // sequencer copy
   logic [CODE_W-1:0]  code_store [NUM_REMOTES];
   logic [FRAME_W-1:0] frame_word;
   phase_type          cur_phase;
   logic [1:0]         repeat_cnt;
   logic [2:0]         sync_cnt;
   logic [6:0]         half_bit;
   logic [TICK_W-1:0]  ticks_left;
   logic               pin_now;

   rsp_type            expected_q [$];
   rsp_type            head_expect;

   function automatic logic [TICK_W-1:0] half_bit_ticks();
      logic [TICK_W-1:0] t;
      t = TICK_W'(symbol_len);
      if (t == '0) begin
         t = TICK_W'(1);
      end
      return t;
   endfunction

   // manchester: a one is low then high, a zero high then low
   function automatic logic manchester_level(input logic [6:0] h);
      logic b;
      b = frame_word[FRAME_W - 1 - h[6:1]];
      return h[0] ? b : ~b;
   endfunction

   function automatic void enter_phase(input phase_type p);
      cur_phase = p;
      case (p)
         PH_WAKE_HI: begin
            pin_now    = 1'b1;
            ticks_left = WAKE_HI_TICKS;
         end
         PH_WAKE_LO: begin
            pin_now    = 1'b0;
            ticks_left = WAKE_LO_TICKS;
         end
         PH_HS_HI: begin
            pin_now    = 1'b1;
            ticks_left = half_bit_ticks() << 2;
         end
         PH_HS_LO: begin
            pin_now    = 1'b0;
            ticks_left = half_bit_ticks() << 2;
         end
         PH_SS_HI: begin
            pin_now    = 1'b1;
            ticks_left = SS_HI_TICKS;
         end
         PH_SS_LO: begin
            pin_now    = 1'b0;
            ticks_left = half_bit_ticks();
         end
         PH_DATA: begin
            pin_now    = manchester_level(half_bit);
            ticks_left = half_bit_ticks();
         end
         PH_GAP: begin
            pin_now    = 1'b0;
            ticks_left = GAP_TICKS;
         end
         default: begin
            cur_phase  = PH_IDLE;
            pin_now    = 1'b0;
            ticks_left = '0;
         end
      endcase
   endfunction

   function automatic void next_phase();
      case (cur_phase)
         PH_WAKE_HI: enter_phase(PH_WAKE_LO);
         PH_WAKE_LO: enter_phase(PH_HS_HI);
         PH_HS_HI:   enter_phase(PH_HS_LO);
         PH_HS_LO: begin
            sync_cnt = sync_cnt - 3'd1;
            if (sync_cnt != 3'd0) begin
               enter_phase(PH_HS_HI);
            end else begin
               enter_phase(PH_SS_HI);
            end
         end
         PH_SS_HI:   enter_phase(PH_SS_LO);
         PH_SS_LO: begin
            half_bit = '0;
            enter_phase(PH_DATA);
         end
         PH_DATA: begin
            half_bit = half_bit + 7'd1;
            if (half_bit < HALF_BITS) begin
               enter_phase(PH_DATA);
            end else begin
               enter_phase(PH_GAP);
            end
         end
         PH_GAP: begin
            repeat_cnt = repeat_cnt + 2'd1;
            if (repeat_cnt < FRAME_REPEATS) begin
               sync_cnt = REPEAT_SYNC;
               enter_phase(PH_HS_HI);
            end else begin
               repeat_cnt = '0;
               enter_phase(PH_IDLE);
            end
         end
         default: enter_phase(PH_IDLE);
      endcase
   endfunction

   // key, button with nibble checksum, code big-endian, address; then xor chained
   function automatic logic [FRAME_W-1:0] build_frame_word(input logic [3:0] idx,
                                                          input logic [3:0] btn,
                                                          input logic [CODE_W-1:0] code);
      logic [0:6][7:0]   frame_bytes;
      logic [ADDR_W-1:0] addr;
      logic [3:0]        nibble_sum;
      addr           = id_base + {20'd0, idx};
      frame_bytes[0] = FRAME_KEY;
      frame_bytes[1] = {btn, 4'h0};
      frame_bytes[2] = code[15:8];
      frame_bytes[3] = code[7:0];
      frame_bytes[4] = addr[23:16];
      frame_bytes[5] = addr[15:8];
      frame_bytes[6] = addr[7:0];
      nibble_sum = '0;
      for (int i = 0; i < 7; i++) begin
         nibble_sum = nibble_sum ^ frame_bytes[i][7:4] ^ frame_bytes[i][3:0];
      end
      frame_bytes[1][3:0] = nibble_sum;
      for (int i = 1; i < 7; i++) begin
         frame_bytes[i] = frame_bytes[i] ^ frame_bytes[i-1];
      end
      return frame_bytes;
   endfunction

   function automatic rsp_type predict_response(input req_type r);
      rsp_type res;
      logic    busy_now;
      logic    ok;
      busy_now = (cur_phase != PH_IDLE);
      ok = !busy_now && (r.remote_index < remotes_used) && (r.remote_index < NUM_REMOTES);
      res = '0;
      case (r.cmd)
         CMD_TICK: begin
            res.pin_level = busy_now ? pin_now : 1'b0;
            if (busy_now) begin
               ticks_left = ticks_left - TICK_W'(1);
               if (ticks_left == '0) begin
                  next_phase();
               end
            end
         end
         CMD_SEND: begin
            if (ok) begin
               res.code_used = code_store[r.remote_index];
               frame_word = build_frame_word(r.remote_index, r.button, res.code_used);
               code_store[r.remote_index] = res.code_used + 16'd1;
               repeat_cnt = '0;
               sync_cnt   = FIRST_SYNC;
               half_bit   = '0;
               enter_phase(PH_WAKE_HI);
               res.accepted = 1'b1;
            end
         end
         CMD_LOAD: begin
            if (ok) begin
               code_store[r.remote_index] = r.code_value;
               res.accepted = 1'b1;
            end
         end
         default: ;
      endcase
      if (r.cmd != CMD_TICK) begin
         res.pin_level = pin_now;
      end
      res.busy_res = (cur_phase != PH_IDLE);
      return res;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         symbol_len   = 16'd640;
         id_base      = '0;
         remotes_used = '0;
         for (int i = 0; i < NUM_REMOTES; i++) begin
            code_store[i] = '0;
         end
         frame_word = '0;
         repeat_cnt = '0;
         sync_cnt   = '0;
         half_bit   = '0;
         enter_phase(PH_IDLE);
         expected_q.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SYMBOL_TICKS:   symbol_len   = csr_wdata[15:0];
               CSR_REMOTE_ID_BASE: id_base      = csr_wdata[ADDR_W-1:0];
               CSR_REMOTE_COUNT:   remotes_used = csr_wdata[4:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("response %0h with no transaction outstanding", rsp_data);
               fail_count++;
            end else begin
               head_expect = expected_q.pop_front();
               compare_field("pin_level", 32'(head_expect.pin_level),
                             32'(rsp_data.pin_level));
               compare_field("busy_res", 32'(head_expect.busy_res),
                             32'(rsp_data.busy_res));
               compare_field("accepted", 32'(head_expect.accepted),
                             32'(rsp_data.accepted));
               compare_field("code_used", 32'(head_expect.code_used),
                             32'(rsp_data.code_used));
            end
         end
         if (req_valid && !req_stall) begin
            expected_q.insert(expected_q.size(), predict_response(req_data));
         end
      end
      pending_results <= expected_q.size();
   end

endmodule

@@ tb/sv/rts_rolling_code_transmitter_unit_tb.sv @@
`timescale 1ns / 1ps

module rts_rolling_code_transmitter_unit_tb;

   import rts_pkg::*;

   localparam int NUM_REMOTES = 16;

   // cmd value with no function
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // the wake pulse alone outlasts the ticks of the last part, so the block stays busy
   localparam int BUSY_TICKS  = 150;
   localparam int QUIET_TICKS = 120;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   int               fail_count;
   int               pending_results;

   // idling knobs, changed only with nonblocking writes
   bit               idling_on  = 1'b1;
   int               gap_odds   = 3;
   int               stall_odds = 3;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rts_rolling_code_transmitter_unit #(
      .NUM_REMOTES(NUM_REMOTES)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rts_rolling_code_transmitter_unit_checker #(
      .NUM_REMOTES(NUM_REMOTES)
   ) i_code_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   function automatic req_type make_req(input logic [1:0] op, input logic [3:0] idx,
                                        input logic [3:0] btn, input logic [15:0] val);
      req_type r;
      r.cmd          = op;
      r.remote_index = idx;
      r.button       = btn;
      r.code_value   = val;
      return r;
   endfunction

   // one transaction on the request side, with an occasional idle burst in front
   task automatic push_request(input req_type item);
      if (idling_on && $urandom_range(0, gap_odds) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   // hold off the sender until every response is back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] val);
      settle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic configure(input logic [15:0] sym, input logic [23:0] base,
                            input logic [4:0] count);
      write_csr(CSR_SYMBOL_TICKS, {8'd0, sym});
      write_csr(CSR_REMOTE_ID_BASE, base);
      write_csr(CSR_REMOTE_COUNT, {19'd0, count});
   endtask

   // random traffic while idle; sends stay out of range so nothing starts
   task automatic idle_traffic(input int n, input int count);
      logic [1:0] op;
      logic [3:0] idx;
      for (int i = 0; i < n; i++) begin
         op  = 2'($urandom_range(0, 3));
         idx = 4'($urandom_range(0, 15));
         if (op == CMD_SEND && idx < count) begin
            idx = 4'($urandom_range(count, 15));
         end
         push_request(make_req(op, idx, 4'($urandom_range(0, 15)),
                               16'($urandom_range(0, 65535))));
         if ($urandom_range(0, 199) == 0) begin
            settle();
         end
      end
   endtask

   // tick transactions, with stray sends, loads and unused commands mixed in that a busy block rejects
   task automatic run_ticks(input int n, input bit with_noise);
      for (int i = 0; i < n; i++) begin
         if (with_noise && $urandom_range(0, 7) == 0) begin
            push_request(make_req(2'($urandom_range(1, 3)), 4'($urandom_range(0, 15)),
                                  4'($urandom_range(0, 15)),
                                  16'($urandom_range(0, 65535))));
         end
         push_request(make_req(CMD_TICK, 4'($urandom_range(0, 15)),
                               4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535))));
      end
   endtask

   // response side stalls in random bursts
   initial begin
      forever begin
         @(posedge clock);
         if (idling_on && $urandom_range(0, stall_odds) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #100_000_000;
      $display("rts_rolling_code_transmitter_unit regression: fail");
      $finish;
   end

   initial begin
      int count;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // no remotes in use: everything but a tick is refused
      write_csr(CSR_REMOTE_COUNT, '0);
      push_request(make_req(CMD_UNUSED, 4'hF, 4'hF, 16'hFFFF));
      push_request(make_req(CMD_TICK, 4'h0, 4'h0, 16'h0000));
      push_request(make_req(CMD_SEND, 4'h0, 4'hF, 16'h0000));
      push_request(make_req(CMD_LOAD, 4'h0, 4'h0, 16'hFFFF));

      // all remotes, widest symbol, top address
      configure(16'hFFFF, 24'hFFFFFF, 5'd16);
      push_request(make_req(CMD_LOAD, 4'hF, 4'h0, 16'hFFFF));
      push_request(make_req(CMD_LOAD, 4'h0, 4'hF, 16'h0000));
      push_request(make_req(CMD_LOAD, 4'h7, 4'h5, 16'hA5A5));
      push_request(make_req(CMD_TICK, 4'hF, 4'hF, 16'hFFFF));
      push_request(make_req(CMD_UNUSED, 4'h0, 4'h0, 16'h0000));
      push_request(make_req(CMD_LOAD, 4'h3, 4'hA, 16'h5A5A));

      // remotes 14 and 15 out of range
      configure(16'd1, 24'd0, 5'd14);
      push_request(make_req(CMD_SEND, 4'hE, 4'h0, 16'h0000));
      push_request(make_req(CMD_LOAD, 4'hE, 4'h0, 16'hFFFF));
      push_request(make_req(CMD_SEND, 4'hF, 4'hF, 16'hFFFF));
      push_request(make_req(CMD_LOAD, 4'hD, 4'h1, 16'h8001));

      // random traffic at two random settings, heavy idling
      count = $urandom_range(0, 14);
      configure(16'($urandom_range(0, 65535)), 24'($urandom_range(0, 24'hFFFFFF)),
                5'(count));
      idle_traffic(650, count);
      count = $urandom_range(1, 14);
      configure(16'($urandom_range(0, 65535)), 24'($urandom_range(0, 24'hFFFFFF)),
                5'(count));
      idle_traffic(650, count);

      // remote 15 holds the top code, zero symbol taken as one, address wraps past the top
      gap_odds   <= 63;
      stall_odds <= 63;
      configure(16'd0, 24'hFFFFFF, 5'd16);
      push_request(make_req(CMD_SEND, 4'hF, 4'($urandom_range(0, 15)),
                            16'($urandom_range(0, 65535))));
      run_ticks(BUSY_TICKS, 1'b1);
      idling_on <= 1'b0;
      run_ticks(QUIET_TICKS, 1'b1);

      settle();
      repeat (6) @(posedge clock);
      if (fail_count == 0) begin
         $display("rts_rolling_code_transmitter_unit regression: pass");
      end else begin
         $display("rts_rolling_code_transmitter_unit regression: fail");
      end
      $finish;
   end

endmodule
